// ===== src/text_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_defines.svh
// Assertion macros used by the text console writer top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property at every rising edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("text console writer assertion failed");

// Check a property at every rising edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("text console writer assertion failed");

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Geometry, codes, field widths and control types of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int BOTTOM     = COLUMNS * (ROWS - 1);

    // Internal widths follow the geometry
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int OFF_W  = $clog2(CELL_COUNT + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    // Stream field widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int OFF_OUT_W  = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_RESP
    } tcw_state_t;

    typedef struct packed {
        logic exec;
        logic copy;
        logic drain;
        logic fill;
        logic load_out;
    } tcw_cmd_t;

    typedef struct packed {
        logic scroll;
        logic is_clear;
        logic cnt_last;
        logic out_free;
    } tcw_stat_t;

endpackage

// ===== src/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: accepts one transfer, runs scroll and clear sweeps,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t  cmd
);
    import tcw_pkg::*;

    tcw_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.scroll) begin
                        state_next = ST_COPY;
                    end else if (stat.is_clear) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_COPY: begin
                if (stat.cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FILL;
            end
            ST_FILL: begin
                if (stat.cnt_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cmd.exec     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.copy     = (state_reg == ST_COPY);
        cmd.drain    = (state_reg == ST_DRAIN);
        cmd.fill     = (state_reg == ST_FILL);
        cmd.load_out = (state_reg == ST_RESP) && stat.out_free;
    end

endmodule

// ===== src/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor registers, screen cell memory, sweep counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    // cmd
    input  logic [tcw_pkg::CMD_W-1:0]      s_tuser,
    // char_code [7:0], color [15:8], cell_index [26:16], zero pad
    input  logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
    input  tcw_pkg::tcw_cmd_t              cmd,
    output tcw_pkg::tcw_stat_t             stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]   m_tdata
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0]  in_code;
    logic [ATTR_W-1:0]  in_color;
    logic [INDEX_W-1:0] in_index;
    logic               is_put, is_nl, is_bs, is_read, idx_ok;

    logic [OFF_W-1:0]   off_reg, off_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               scrolled_reg;
    logic               rd_sel_reg;
    logic [ATTR_W-1:0]  color_reg;
    logic [ADDR_W-1:0]  cnt_reg;
    logic               cp_wr_reg;
    logic [ADDR_W-1:0]  cp_addr_reg;

    logic [CELL_W-1:0]  mem [CELL_COUNT];
    logic [CELL_W-1:0]  rdata_reg;
    logic               we, re;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [CELL_W-1:0]  wdata;
    logic               put_we;
    logic [ADDR_W-1:0]  put_addr;
    logic [CELL_W-1:0]  put_data;

    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [CHAR_W-1:0]  glyph_out;
    logic [ATTR_W-1:0]  attr_out;

    assign in_code  = s_tdata[CHAR_W-1:0];
    assign in_color = s_tdata[CHAR_W +: ATTR_W];
    assign in_index = s_tdata[CELL_W +: INDEX_W];
    assign is_put   = (s_tuser == CMD_PUT);
    assign is_read  = (s_tuser == CMD_READ);
    assign is_nl    = (in_code == CODE_NEWLINE);
    assign is_bs    = (in_code == CODE_BACKSPACE);
    assign idx_ok   = ({1'b0, in_index} < (INDEX_W + 1)'(CELL_COUNT));

    // Cursor update for a put, without the scroll fix-up
    always_comb begin
        off_next = off_reg;
        row_next = row_reg;
        col_next = col_reg;
        priority if (is_nl) begin
            off_next = off_reg + (OFF_W'(COLUMNS) - OFF_W'(col_reg));
            row_next = row_reg + ROW_W'(1);
            col_next = '0;
        end else if (is_bs) begin
            if (off_reg != '0) begin
                off_next = off_reg - OFF_W'(1);
                if (col_reg == '0) begin
                    col_next = COL_W'(COLUMNS - 1);
                    row_next = row_reg - ROW_W'(1);
                end else begin
                    col_next = col_reg - COL_W'(1);
                end
            end
        end else begin
            off_next = off_reg + OFF_W'(1);
            if (col_reg == COL_W'(COLUMNS - 1)) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    assign stat.scroll   = is_put && (row_next == ROW_W'(ROWS));
    assign stat.is_clear = (s_tuser == CMD_CLEAR);
    assign stat.cnt_last = (cnt_reg == ADDR_W'(CELL_COUNT - 1));
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Cell written by a put: backspace blanks the cell before the cursor
    assign put_we   = cmd.exec && is_put && !is_nl && (!is_bs || (off_reg != '0));
    assign put_addr = is_bs ? ADDR_W'(off_reg - OFF_W'(1)) : ADDR_W'(off_reg);
    assign put_data = {in_color, (is_bs ? CODE_SPACE : in_code)};

    always_comb begin
        priority if (cp_wr_reg) begin
            we    = 1'b1;
            waddr = cp_addr_reg;
            wdata = rdata_reg;
        end else if (cmd.fill) begin
            we    = 1'b1;
            waddr = cnt_reg;
            wdata = {color_reg, CODE_SPACE};
        end else begin
            we    = put_we;
            waddr = put_addr;
            wdata = put_data;
        end
    end

    assign re    = cmd.copy || (cmd.exec && is_read && idx_ok);
    assign raddr = cmd.copy ? cnt_reg : ADDR_W'(in_index);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            cp_wr_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cp_wr_reg <= cmd.copy;
            if (cmd.exec) begin
                if (stat.scroll) begin
                    off_reg <= OFF_W'(BOTTOM);
                    row_reg <= ROW_W'(ROWS - 1);
                    col_reg <= '0;
                end else if (stat.is_clear) begin
                    off_reg <= '0;
                    row_reg <= '0;
                    col_reg <= '0;
                end else if (is_put) begin
                    off_reg <= off_next;
                    row_reg <= row_next;
                    col_reg <= col_next;
                end
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            scrolled_reg <= stat.scroll;
            rd_sel_reg   <= is_read && idx_ok;
            color_reg    <= in_color;
            cnt_reg      <= stat.scroll ? ADDR_W'(COLUMNS) : '0;
        end else if (cmd.drain) begin
            cnt_reg <= ADDR_W'(BOTTOM);
        end else if (cmd.copy || cmd.fill) begin
            cnt_reg <= cnt_reg + ADDR_W'(1);
        end
        // Destination of the cell read this cycle lands one row up
        cp_addr_reg <= cnt_reg - ADDR_W'(COLUMNS);
        if (cmd.load_out) begin
            m_tdata_reg <= {attr_out, glyph_out, scrolled_reg,
                            COL_OUT_W'(col_reg), ROW_OUT_W'(row_reg), OFF_OUT_W'(off_reg)};
        end
    end

    assign glyph_out = rd_sel_reg ? rdata_reg[CHAR_W-1:0] : '0;
    assign attr_out  = rd_sel_reg ? rdata_reg[CELL_W-1:CHAR_W] : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/text_console_writer.sv =====
// Sequence: put, read and unused commands go from accepting the transfer straight to loading the
// output register; clear first sweeps the screen, a put that scrolls copies it up a row and clears the bottom.
// A new transfer is taken only after the output register has been loaded;
// scroll and clear sweep the screen cell memory one cell per cycle.
// Reset: synchronous active-low aresetn homes the cursor and empties the output
// register; screen cells keep no reset value and hold garbage until written.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with newline, backspace, scroll, clear and read.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd
    input  logic [tcw_pkg::CMD_W-1:0]      s_tuser,
    // char_code [7:0], color [15:8], cell_index [26:16], zero pad [31:27]
    input  logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cursor_offset [10:0], cursor_row [15:11], cursor_col [22:16], scrolled [23],
    // read_glyph [31:24], read_attr [39:32]
    output logic [tcw_pkg::M_DATA_W-1:0]   m_tdata
);
    import tcw_pkg::*;

    tcw_cmd_t  cmd;
    tcw_stat_t stat;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // One command in flight: after a transfer in, hold off the next one
    `TCW_ASSERT(a_one_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)

    // Reported cursor stays on screen
    `TCW_ASSERT(a_cursor_on_screen, aclk, aresetn, m_tvalid |-> ((m_tdata[15:11] < ROW_OUT_W'(ROWS)) && (m_tdata[22:16] < COL_OUT_W'(COLUMNS))))

    // Offset agrees with row and column
    `TCW_ASSERT(a_cursor_consistent, aclk, aresetn, m_tvalid |-> ({5'd0, m_tdata[10:0]} == (16'(m_tdata[15:11]) * 16'(COLUMNS) + 16'(m_tdata[22:16]))))

    // Sweeps never overlap an accepted transfer
    `TCW_ASSERT(a_no_sweep_on_accept, aclk, aresetn, (s_tvalid && s_tready) |-> !(cmd.copy || cmd.fill || cmd.drain))

endmodule
